// ----- src/rlbd_pkg.sv -----
`default_nettype none

package rlbd_pkg;

    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 8;
    localparam int OUT_BYTES_W = 32;
    localparam int OUT_LANES   = OUT_BYTES_W / BYTE_W;
    localparam int OUT_COUNT_W = 3;
    localparam int TOTAL_OUT_W = 16;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [RUN_W-1:0] LIT_BIAS = RUN_W'(1);
    localparam logic [RUN_W-1:0] REP_BIAS = RUN_W'(3);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT    = 2'd0,
        CMD_REP    = 2'd1,
        CMD_STATUS = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BYTE_W-1:0]  data;
        logic [RUN_W-1:0]   count;
        logic               last;
        logic               err;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/rlbd_front.sv -----
`default_nettype none

module rlbd_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,
    input  wire logic                      s_tlast,
    input  wire logic                      q_full,
    output logic                           q_push,
    output rlbd_pkg::cmd_t                 q_cmd
);
    import rlbd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [RUN_W-1:0]   left_reg, left_next;
    logic               accept;
    logic [RUN_W-1:0]   left_dec;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign left_dec = left_reg - RUN_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            left_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        if (accept) begin
            case (phase_reg)
                PH_LITERAL: begin
                    if (s_tlast || left_dec == '0) begin
                        phase_next = PH_HEADER;
                        left_next  = '0;
                    end else begin
                        left_next  = left_dec;
                    end
                end
                PH_REPEAT: begin
                    phase_next = PH_HEADER;
                    left_next  = '0;
                end
                default: begin
                    if (s_tlast) begin
                        phase_next = PH_HEADER;
                        left_next  = '0;
                    end else if (s_tdata[7]) begin
                        phase_next = PH_REPEAT;
                        left_next  = RUN_W'(s_tdata[6:0]) + REP_BIAS;
                    end else begin
                        phase_next = PH_LITERAL;
                        left_next  = RUN_W'(s_tdata[6:0]) + LIT_BIAS;
                    end
                end
            endcase
        end
    end

    // word classification into back-end commands
    always_comb begin
        q_push      = 1'b0;
        q_cmd.kind  = CMD_STATUS;
        q_cmd.data  = s_tdata;
        q_cmd.count = left_reg;
        q_cmd.last  = s_tlast;
        q_cmd.err   = 1'b0;
        case (phase_reg)
            PH_LITERAL: begin
                q_push     = accept;
                q_cmd.kind = CMD_LIT;
                q_cmd.err  = s_tlast && (left_dec != '0);
            end
            PH_REPEAT: begin
                q_push     = accept;
                q_cmd.kind = CMD_REP;
            end
            default: begin
                // header closing the packet: the run can never finish
                q_push     = accept && s_tlast;
                q_cmd.kind = CMD_STATUS;
                q_cmd.err  = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/rlbd_queue.sv -----
`default_nettype none

module rlbd_queue (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire rlbd_pkg::cmd_t            push_cmd,
    output logic                           full,
    input  wire logic                      pop,
    output logic                           head_valid,
    output rlbd_pkg::cmd_t                 head_cmd
);
    import rlbd_pkg::*;

    cmd_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- src/rlbd_back.sv -----
`default_nettype none

module rlbd_back #(
    parameter int LANES       = 4,
    parameter int TOTAL_WIDTH = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      head_valid,
    input  wire rlbd_pkg::cmd_t            head_cmd,
    output logic                           pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [55:0]                    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import rlbd_pkg::*;

    localparam logic [RUN_W-1:0] LANES_N = RUN_W'(LANES);

    logic                       valid_reg, valid_next;
    logic [OUT_BYTES_W-1:0]     bytes_reg, bytes_next;
    logic [OUT_COUNT_W-1:0]     count_reg, count_next;
    logic [TOTAL_OUT_W-1:0]     dtotal_reg, dtotal_next;
    logic                       last_reg, last_next;
    logic                       err_reg, err_next;
    logic [TOTAL_WIDTH-1:0]     total_reg, total_next;
    logic [RUN_W-1:0]           sent_reg, sent_next;

    logic                       load;
    logic                       final_chunk;
    logic [RUN_W-1:0]           left;
    logic [RUN_W-1:0]           chunk;
    logic [TOTAL_WIDTH:0]       sum;
    logic [TOTAL_WIDTH-1:0]     new_total;
    logic [OUT_BYTES_W-1:0]     packed_bytes;

    assign load = head_valid && (!valid_reg || m_tready);
    assign left = head_cmd.count - sent_reg;

    always_comb begin
        case (head_cmd.kind)
            CMD_LIT: begin
                chunk       = RUN_W'(1);
                final_chunk = 1'b1;
            end
            CMD_REP: begin
                chunk       = (left > LANES_N) ? LANES_N : left;
                final_chunk = (left <= LANES_N);
            end
            default: begin
                chunk       = '0;
                final_chunk = 1'b1;
            end
        endcase
    end

    assign pop = load && final_chunk;

    // saturating packet total
    always_comb begin
        sum       = {1'b0, total_reg} + (TOTAL_WIDTH + 1)'(chunk);
        new_total = sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
    end

    // lanes beyond the output word are dropped
    always_comb begin
        for (int i = 0; i < OUT_LANES; i++) begin
            packed_bytes[i*BYTE_W +: BYTE_W] =
                (RUN_W'(i) < chunk) ? head_cmd.data : '0;
        end
    end

    always_comb begin
        valid_next  = valid_reg;
        bytes_next  = bytes_reg;
        count_next  = count_reg;
        dtotal_next = dtotal_reg;
        last_next   = last_reg;
        err_next    = err_reg;
        total_next  = total_reg;
        sent_next   = sent_reg;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next  = 1'b1;
            bytes_next  = packed_bytes;
            count_next  = chunk[OUT_COUNT_W-1:0];
            dtotal_next = TOTAL_OUT_W'(new_total);
            last_next   = head_cmd.last && final_chunk;
            err_next    = head_cmd.err && head_cmd.last && final_chunk;
            total_next  = (head_cmd.last && final_chunk) ? '0 : new_total;
            sent_next   = final_chunk ? '0 : sent_reg + LANES_N;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            total_reg <= '0;
            sent_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            total_reg <= total_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge aclk) begin
        bytes_reg  <= bytes_next;
        count_reg  <= count_next;
        dtotal_reg <= dtotal_next;
        last_reg   <= last_next;
        err_reg    <= err_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'b0, dtotal_reg, count_reg, bytes_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = err_reg;

endmodule

`default_nettype wire

// ----- src/run_length_byte_decoder_core.sv -----
`default_nettype none

// channel   dir  tdata (low bit up)                                  tlast     tuser
// s_        in   in_byte[7:0]                                        in_last   -
// m_        out  out_bytes[31:0] out_count[34:32] decoded_total[50:35] out_last format_error
//
// the front takes one word a cycle while the two-entry command queue has room;
// headers produce no command unless they close a packet. the back emits one
// result per literal or status command and ceil(n / LANES) results for an n-byte
// repeat. an input word passes the command queue and the output register before
// its first result appears. aresetn is synchronous; it returns the front to
// header phase, empties the queue and clears the packet total. a stalled m_ side
// fills the queue and then drops s_tready.
module run_length_byte_decoder_core #(
    parameter int LANES       = 4,
    parameter int TOTAL_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,     // in_byte[7:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,     // out_bytes[31:0] out_count[34:32] decoded_total[50:35]
    output logic             m_tlast,
    output logic             m_tuser      // format_error[0]
);
    import rlbd_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   head_valid;
    cmd_t   push_cmd;
    cmd_t   head_cmd;

    rlbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    rlbd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rlbd_back #(
        .LANES       (LANES),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

    a_no_empty_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> head_valid)
        else $error("command popped from empty queue");

    a_err_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("format error outside last word");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (LANES < 8 && m_tvalid && m_tdata[34:32] == 3'd0) |-> m_tlast)
        else $error("empty word not closing a packet");

endmodule

`default_nettype wire
